// ----- hw/rtl/dsa_pkg.sv -----
// Shared constants, codes and types of the descriptor slot allocator.
package dsa_pkg;

    // Table size and derived widths
    localparam int MAX_SLOTS = 1024;
    localparam int ADDR_W    = $clog2(MAX_SLOTS);
    localparam int DEPTH_W   = $clog2(MAX_SLOTS + 1);

    // Fixed field widths
    localparam int KIND_W  = 1;
    localparam int CNT_W   = 11;
    localparam int IDX_W   = 10;
    localparam int INC_W   = 16;
    localparam int ADDR64  = 64;
    localparam int OFF_W   = IDX_W + INC_W;
    localparam int STAT_W  = 3;
    localparam int CFG_IDX_W = 2;

    // Stream payload widths (padded to whole bytes)
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 144;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_ALLOC   = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_FREED   = 3'd2,
        ST_IGNORED = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE  = 2'd3;

    // Reset values of the registers
    localparam logic [CNT_W-1:0] CAPACITY_RST  = CNT_W'(1024);
    localparam logic [INC_W-1:0] INCREMENT_RST = INC_W'(32);

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_ADD  = 3'b100
    } t_state;

endpackage

// ----- hw/rtl/descriptor_slot_allocator_unit.sv -----
// Descriptor slot allocator: free-stack pop or bump allocation with address generation.
// An accepted request beat goes through the stack read, the multiply and the add into the output register.
// One request is in flight at a time: the next is not taken until the last one's result is loaded.
// The next request is taken while a finished result still waits on the output register.
// Reset (synchronous, active low) empties the free stack, zeroes the bump pointer and
// loads capacity 1024, increment 32 and zero bases; stack contents are not cleared.
module descriptor_slot_allocator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [dsa_pkg::S_DATA_W-1:0]    i_s_tdata,  // [10:0] count, [20:11] slot_index
    input  logic [dsa_pkg::KIND_W-1:0]      i_s_tuser,  // [0] kind
    // Result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [dsa_pkg::M_DATA_W-1:0]    o_m_tdata,  // [9:0] granted_index,
                                                        // [73:10] cpu_address,
                                                        // [137:74] gpu_address
    output logic [dsa_pkg::STAT_W-1:0]      o_m_tuser,  // [2:0] status
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                     i_cfg_data
);

    // Configuration registers
    logic [dsa_pkg::CNT_W-1:0]  r_capacity;
    logic [dsa_pkg::INC_W-1:0]  r_increment;
    logic [dsa_pkg::ADDR64-1:0] r_cpu_base;
    logic [dsa_pkg::ADDR64-1:0] r_gpu_base;

    // Allocator state
    logic [dsa_pkg::DEPTH_W-1:0] r_depth, n_depth;
    logic [dsa_pkg::CNT_W-1:0]   r_next_slot, n_next_slot;
    dsa_pkg::t_state             r_state;

    // Free stack memory
    logic [dsa_pkg::IDX_W-1:0]  r_stack [dsa_pkg::MAX_SLOTS];
    logic [dsa_pkg::IDX_W-1:0]  r_rd_data;

    // Per-request work registers
    dsa_pkg::t_status           r_status, n_status;
    logic                       r_ok, n_ok;
    logic                       r_pop, n_pop;
    logic                       n_push;
    logic [dsa_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [dsa_pkg::IDX_W-1:0]  r_gidx;
    logic [dsa_pkg::OFF_W-1:0]  r_off;
    logic [dsa_pkg::ADDR_W-1:0] n_addr;

    // Output register
    logic                       r_o_valid;
    dsa_pkg::t_status           r_o_status;
    logic [dsa_pkg::IDX_W-1:0]  r_o_idx;
    logic [dsa_pkg::ADDR64-1:0] r_o_cpu;
    logic [dsa_pkg::ADDR64-1:0] r_o_gpu;

    logic                       accept;
    logic                       out_load;
    logic [dsa_pkg::KIND_W-1:0] req_kind;
    logic [dsa_pkg::CNT_W-1:0]  req_count;
    logic [dsa_pkg::IDX_W-1:0]  req_slot;
    logic [dsa_pkg::CNT_W-1:0]  cap;
    logic [dsa_pkg::CNT_W:0]    bump_end;
    logic [dsa_pkg::IDX_W-1:0]  mul_idx;

    // Take no beat while reset is held
    assign o_s_tready  = i_rst_n && (r_state == dsa_pkg::S_IDLE);
    assign o_cfg_ready = i_rst_n;
    assign accept      = i_s_tvalid && o_s_tready;
    assign out_load    = (r_state == dsa_pkg::S_ADD) && (!r_o_valid || i_m_tready);

    assign req_kind  = i_s_tuser;
    assign req_count = i_s_tdata[dsa_pkg::CNT_W-1:0];
    assign req_slot  = i_s_tdata[dsa_pkg::CNT_W +: dsa_pkg::IDX_W];

    // Clamp capacity to the table size and form the bump end
    assign cap      = (r_capacity > dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS))
                      ? dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS) : r_capacity;
    assign bump_end = {1'b0, r_next_slot} + {1'b0, req_count};

    // Decide the request: pop, bump, push or reject
    always_comb begin
        n_status    = dsa_pkg::ST_NOSPACE;
        n_ok        = 1'b0;
        n_pop       = 1'b0;
        n_push      = 1'b0;
        n_idx       = '0;
        n_depth     = r_depth;
        n_next_slot = r_next_slot;
        n_addr      = r_depth[dsa_pkg::ADDR_W-1:0];
        if (req_kind == dsa_pkg::KIND_ALLOC) begin
            priority if (req_count == dsa_pkg::CNT_W'(1) && r_depth != '0) begin
                n_depth  = r_depth - dsa_pkg::DEPTH_W'(1);
                n_addr   = n_depth[dsa_pkg::ADDR_W-1:0];
                n_pop    = 1'b1;
                n_ok     = 1'b1;
                n_status = dsa_pkg::ST_ALLOC;
            end else if (bump_end > {1'b0, cap} || r_next_slot >= cap) begin
                n_status = dsa_pkg::ST_NOSPACE;
            end else begin
                n_idx       = r_next_slot[dsa_pkg::IDX_W-1:0];
                n_next_slot = bump_end[dsa_pkg::CNT_W-1:0];
                n_ok        = 1'b1;
                n_status    = dsa_pkg::ST_ALLOC;
            end
        end else begin
            priority if (req_count != dsa_pkg::CNT_W'(1)) begin
                n_status = dsa_pkg::ST_IGNORED;
            end else if (r_depth >= dsa_pkg::DEPTH_W'(dsa_pkg::MAX_SLOTS)) begin
                n_status = dsa_pkg::ST_FULL;
            end else begin
                n_push   = 1'b1;
                n_depth  = r_depth + dsa_pkg::DEPTH_W'(1);
                n_status = dsa_pkg::ST_FREED;
            end
        end
    end

    // Free stack: one write or one registered read per request
    always_ff @(posedge i_clk) begin
        if (accept && n_push) begin
            r_stack[n_addr] <= req_slot;
        end
        if (accept && n_pop) begin
            r_rd_data <= r_stack[n_addr];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= dsa_pkg::CAPACITY_RST;
            r_increment <= dsa_pkg::INCREMENT_RST;
            r_cpu_base  <= '0;
            r_gpu_base  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                dsa_pkg::CFG_CAPACITY:  r_capacity  <= i_cfg_data[dsa_pkg::CNT_W-1:0];
                dsa_pkg::CFG_INCREMENT: r_increment <= i_cfg_data[dsa_pkg::INC_W-1:0];
                dsa_pkg::CFG_CPU_BASE:  r_cpu_base  <= i_cfg_data;
                dsa_pkg::CFG_GPU_BASE:  r_gpu_base  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and allocator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsa_pkg::S_IDLE;
            r_depth     <= '0;
            r_next_slot <= '0;
        end else begin
            unique case (r_state)
                dsa_pkg::S_IDLE: begin
                    if (accept) begin
                        r_depth     <= n_depth;
                        r_next_slot <= n_next_slot;
                        r_state     <= dsa_pkg::S_MUL;
                    end
                end
                dsa_pkg::S_MUL: r_state <= dsa_pkg::S_ADD;
                dsa_pkg::S_ADD: begin
                    if (out_load) begin
                        r_state <= dsa_pkg::S_IDLE;
                    end
                end
                default: r_state <= dsa_pkg::S_IDLE;
            endcase
        end
    end

    // Capture the request decision
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_ok     <= n_ok;
            r_pop    <= n_pop;
            r_idx    <= n_idx;
        end
    end

    // Multiply the granted index by the slot increment
    assign mul_idx = r_pop ? r_rd_data : r_idx;

    always_ff @(posedge i_clk) begin
        if (r_state == dsa_pkg::S_MUL) begin
            r_gidx <= mul_idx;
            r_off  <= dsa_pkg::OFF_W'(mul_idx) * dsa_pkg::OFF_W'(r_increment);
        end
    end

    // Output register: add bases, hold until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (r_o_valid && i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_status;
            if (r_ok) begin
                r_o_idx <= r_gidx;
                r_o_cpu <= r_cpu_base + dsa_pkg::ADDR64'(r_off);
                r_o_gpu <= r_gpu_base + dsa_pkg::ADDR64'(r_off);
            end else begin
                r_o_idx <= '0;
                r_o_cpu <= '0;
                r_o_gpu <= '0;
            end
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o_status;
    assign o_m_tdata  = {6'b0, r_o_gpu, r_o_cpu, r_o_idx};

endmodule

// ----- hw/rtl/dsa_checker.sv -----
// Port-level checks of the descriptor slot allocator, bound to its top level.
module dsa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [dsa_pkg::M_DATA_W-1:0]    o_m_tdata,
    input logic [dsa_pkg::STAT_W-1:0]      o_m_tuser
);

    // Reset leaves no result beat pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat valid after reset");

    // Hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result beat changed");

    // Anything but a grant carries zero index and addresses
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != dsa_pkg::ST_ALLOC |-> o_m_tdata == '0)
        else $error("non-grant result with nonzero payload");

    // One request in flight: ready drops after an accepted beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while another is in flight");

endmodule

bind descriptor_slot_allocator_unit dsa_checker u_dsa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ----- verif/tb.sv -----
// Testbench for the descriptor slot allocator: mirrored allocator state checks every reply beat.
module tb;
    import dsa_pkg::*;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] index;
        logic [63:0]      cpu;
        logic [63:0]      gpu;
    } t_reply;

    // Mirror of the allocator: registers, free stack and bump pointer, plus replies still due
    class allocator_mirror;
        int unsigned      capacity;
        logic [INC_W-1:0] increment;
        logic [63:0]      cpu_base;
        logic [63:0]      gpu_base;
        logic [IDX_W-1:0] freed[MAX_SLOTS];
        int unsigned      depth;
        int unsigned      bump;
        t_reply           due_replies[$];
        int unsigned      mismatches;

        function new();
            capacity   = 1024;
            increment  = 32;
            cpu_base   = '0;
            gpu_base   = '0;
            depth      = 0;
            bump       = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
            case (idx)
                CFG_CAPACITY:  capacity  = val[CNT_W-1:0];
                CFG_INCREMENT: increment = val[INC_W-1:0];
                CFG_CPU_BASE:  cpu_base  = val;
                CFG_GPU_BASE:  gpu_base  = val;
                default: ;
            endcase
        endfunction

        // Advance the mirrored state by one request beat and queue the reply it must give
        function void take_request(logic [KIND_W-1:0] kind, logic [CNT_W-1:0] count,
                                   logic [IDX_W-1:0] slot);
            t_reply           r;
            int unsigned      lim;
            logic [IDX_W-1:0] grant;
            logic [63:0]      off;
            bit               ok;
            r.status = ST_ALLOC;
            r.index  = '0;
            r.cpu    = '0;
            r.gpu    = '0;
            ok       = 1'b0;
            grant    = '0;
            lim      = (capacity < MAX_SLOTS) ? capacity : MAX_SLOTS;
            if (kind == KIND_ALLOC) begin
                if (count == 1 && depth > 0) begin
                    depth--;
                    grant = freed[depth];
                    ok    = 1'b1;
                end else if (bump + count > lim || bump >= lim) begin
                    r.status = ST_NOSPACE;
                end else begin
                    grant = IDX_W'(bump);
                    bump += count;
                    ok    = 1'b1;
                end
            end else if (count != 1) begin
                r.status = ST_IGNORED;
            end else if (depth >= MAX_SLOTS) begin
                r.status = ST_FULL;
            end else begin
                freed[depth] = slot;
                depth++;
                r.status = ST_FREED;
            end
            if (ok) begin
                off     = 64'(grant) * 64'(increment);
                r.index = grant;
                r.cpu   = cpu_base + off;
                r.gpu   = gpu_base + off;
            end
            due_replies = {due_replies, r};
        endfunction

        // Compare one reply beat against the oldest reply due
        function void match_reply(t_status status, logic [IDX_W-1:0] index,
                                  logic [63:0] cpu, logic [63:0] gpu);
            t_reply want;
            if (due_replies.size() == 0) begin
                $display("%0t: unexpected reply beat: status %0d index %0d",
                         $time, status, index);
                mismatches++;
                return;
            end
            want = due_replies.pop_front();
            if (status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, status);
                mismatches++;
            end
            if (index !== want.index) begin
                $display("%0t: granted index expected %0d got %0d", $time, want.index, index);
                mismatches++;
            end
            if (cpu !== want.cpu) begin
                $display("%0t: cpu address expected %h got %h", $time, want.cpu, cpu);
                mismatches++;
            end
            if (gpu !== want.gpu) begin
                $display("%0t: gpu address expected %h got %h", $time, want.gpu, gpu);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata   = '0;
    logic [KIND_W-1:0]     i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic [STAT_W-1:0]     o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [63:0]           i_cfg_data  = '0;

    allocator_mirror mirror = new();
    int unsigned     sent      = 0;
    bit              src_burst = 1'b0;

    descriptor_slot_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Note request beats and check reply beats as the handshakes complete
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready === 1'b1)
                mirror.take_request(i_s_tuser, i_s_tdata[CNT_W-1:0],
                                    i_s_tdata[CNT_W +: IDX_W]);
            if (o_m_tvalid === 1'b1 && i_m_tready)
                mirror.match_reply(t_status'(o_m_tuser), o_m_tdata[IDX_W-1:0],
                                   o_m_tdata[IDX_W +: 64], o_m_tdata[IDX_W+64 +: 64]);
        end
    end

    // Reply sink: random stalls, burst stretches and two long hold-offs that back up the block
    initial begin : reply_sink
        int unsigned taken;
        int unsigned pause;
        bit          burst;
        taken = 0;
        burst = 1'b0;
        forever begin
            if (taken % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            if (taken == 30 || taken == 400)
                pause = 150;
            else
                pause = burst ? 0 : $urandom_range(0, 7);
            if (pause > 0) begin
                i_m_tready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
            taken++;
        end
    end

    // Offer one request beat after a random gap and hold it until taken
    task automatic send_request(logic [KIND_W-1:0] kind, logic [CNT_W-1:0] count,
                                logic [IDX_W-1:0] slot);
        int unsigned gap;
        if (sent % 40 == 0)
            src_burst = ($urandom_range(0, 2) == 0);
        gap = src_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, slot, count};
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        sent++;
    endtask

    task automatic random_requests(int n);
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  count;
        int unsigned       pick;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 0) begin
                kind = KIND_ALLOC;
                if (pick < 60)      count = 1;
                else if (pick < 75) count = 0;
                else if (pick < 92) count = CNT_W'($urandom_range(2, 4));
                else                count = CNT_W'($urandom_range(0, 1024));
            end else begin
                kind = KIND_FREE;
                if (pick < 80)      count = 1;
                else if (pick < 90) count = 0;
                else                count = CNT_W'($urandom_range(2, 1024));
            end
            send_request(kind, count, IDX_W'($urandom));
        end
    endtask

    // Drop valid, wait for every due reply, then let the pipeline drain
    task automatic settle();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (mirror.due_replies.size() > 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        mirror.write_reg(idx, val);
    endtask

    task automatic write_config(logic [63:0] cap, logic [63:0] inc,
                                logic [63:0] cpu, logic [63:0] gpu);
        cfg_beat(CFG_CAPACITY, cap);
        cfg_beat(CFG_INCREMENT, inc);
        cfg_beat(CFG_CPU_BASE, cpu);
        cfg_beat(CFG_GPU_BASE, gpu);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: zero-count grant, bump, LIFO pops, ignored frees, oversize request
        send_request(KIND_ALLOC, 0, 10'h155);
        send_request(KIND_ALLOC, 1, 10'h000);
        send_request(KIND_ALLOC, 3, 10'h3FF);
        send_request(KIND_FREE, 1, 10'h3FF);
        send_request(KIND_FREE, 1, 10'h000);
        send_request(KIND_FREE, 1, 10'h2AA);
        send_request(KIND_ALLOC, 2, 10'h000);
        send_request(KIND_ALLOC, 1, 10'h000);
        send_request(KIND_ALLOC, 1, 10'h000);
        send_request(KIND_ALLOC, 1, 10'h000);
        send_request(KIND_ALLOC, 1, 10'h000);
        send_request(KIND_FREE, 0, 10'h155);
        send_request(KIND_FREE, 2, 10'h000);
        send_request(KIND_FREE, 1024, 10'h3FF);
        send_request(KIND_ALLOC, 1024, 10'h3FF);
        settle();

        // Small table: fill it exactly, then run out; a pop still succeeds when full
        write_config(64'd12, 64'hFFFF, '1, '0);
        send_request(KIND_ALLOC, CNT_W'(12 - mirror.bump), 10'h000);
        send_request(KIND_ALLOC, 0, 10'h000);
        send_request(KIND_ALLOC, 1, 10'h000);
        send_request(KIND_FREE, 1, 10'h155);
        send_request(KIND_ALLOC, 1, 10'h000);
        send_request(KIND_ALLOC, 1, 10'h000);
        random_requests(125);
        settle();

        // Zero capacity, zero increment: only pops can grant
        write_config(64'd0, 64'd0, {$urandom, $urandom}, '1);
        random_requests(125);
        settle();

        // Capacity beyond the table size clamps to the table
        write_config(64'd1500, 64'($urandom_range(0, 65535)), {$urandom, $urandom},
                     {$urandom, $urandom});
        random_requests(125);
        settle();

        // Widest increment with all-ones bases to exercise address wrap
        write_config(64'd1024, 64'hFFFF, '1, '1);
        random_requests(125);
        settle();

        if (mirror.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #1600000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
